// File: rtl/tao_pkg.sv
// Shared types and constants for the tile alpha occupancy scan unit.
// No dependencies; imported by every module of the block.
`default_nettype none

package tao_pkg;

  localparam int DEF_MAX_COLUMNS   = 64;
  localparam int DEF_MAX_TILE_DIM  = 256;
  localparam int DEF_MAX_IMAGE_DIM = 4096;

  localparam int SUM_W = 24;
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  localparam logic [23:0] RST_FRAME_WIDTH    = 24'd64;
  localparam logic [23:0] RST_FRAME_HEIGHT   = 24'd64;
  localparam logic [23:0] RST_IMAGE_WIDTH    = 24'd64;
  localparam logic [23:0] RST_IMAGE_HEIGHT   = 24'd64;
  localparam logic [23:0] RST_COLUMN_COUNT   = 24'd1;
  localparam logic [23:0] RST_ROW_COUNT      = 24'd1;
  localparam logic [23:0] RST_ALPHA_THRESH   = 24'd1800;

  localparam logic [6:0] CNT_SAT = 7'd127;

  typedef enum logic [2:0] {
    REG_FRAME_WIDTH     = 3'd0,
    REG_FRAME_HEIGHT    = 3'd1,
    REG_IMAGE_WIDTH     = 3'd2,
    REG_IMAGE_HEIGHT    = 3'd3,
    REG_COLUMN_COUNT    = 3'd4,
    REG_ROW_COUNT       = 3'd5,
    REG_ALPHA_THRESHOLD = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [8:0]       frame_width;
    logic [8:0]       frame_height;
    logic [12:0]      image_width;
    logic [12:0]      image_height;
    logic [6:0]       column_count;
    logic [6:0]       row_count;
    logic [SUM_W-1:0] alpha_threshold;
  } cfg_t;

  // one pixel as it leaves the position tracker
  typedef struct packed {
    logic [7:0] alpha;
    logic [6:0] col;
    logic [6:0] band;
    logic       start;
    logic       y0;
    logic       tile_end;
    logic       band_end;
    logic       img_end;
    logic       band_reset;
  } pix_t;

  typedef struct packed {
    logic [5:0] band_index;
    logic [6:0] run_length;
    logic [6:0] effective_count;
    logic       last_band;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/tao_pos.sv
// Raster position tracker: pixel, in-tile and tile counters.
// Depends on tao_pkg; feeds the pixel descriptor to tao_accum.
`default_nettype none

module tao_pos
  import tao_pkg::*;
#(
  parameter int MAX_TILE_DIM  = DEF_MAX_TILE_DIM,
  parameter int MAX_IMAGE_DIM = DEF_MAX_IMAGE_DIM
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire cfg_t       cfg,
  input  wire logic       accept,
  input  wire logic [7:0] alpha,
  input  wire logic       start_image,
  output pix_t            pix
);

  localparam int TDW = (MAX_TILE_DIM > 1) ? $clog2(MAX_TILE_DIM) : 1;
  localparam int IDW = (MAX_IMAGE_DIM > 1) ? $clog2(MAX_IMAGE_DIM) : 1;

  logic [11:0] pixel_x, pixel_y, pixel_x_next, pixel_y_next;
  logic [7:0]  x_in_tile, y_in_tile, x_in_tile_next, y_in_tile_next;
  logic [6:0]  tile_column, tile_band, tile_column_next, tile_band_next;

  logic [11:0] cx, cy;
  logic [7:0]  cxt, cyt;
  logic [6:0]  ctc, ctb;
  logic [TDW-1:0] fw_m1, fh_m1;
  logic [IDW-1:0] iw_m1, ih_m1;
  logic x_end, y_end, row_end, img_end;

  always_comb begin
    if (cfg.frame_width == 9'd0) fw_m1 = '0;
    else if ({23'd0, cfg.frame_width} > MAX_TILE_DIM) fw_m1 = TDW'(MAX_TILE_DIM - 1);
    else fw_m1 = TDW'(cfg.frame_width - 9'd1);

    if (cfg.frame_height == 9'd0) fh_m1 = '0;
    else if ({23'd0, cfg.frame_height} > MAX_TILE_DIM) fh_m1 = TDW'(MAX_TILE_DIM - 1);
    else fh_m1 = TDW'(cfg.frame_height - 9'd1);

    if (cfg.image_width == 13'd0) iw_m1 = '0;
    else if ({19'd0, cfg.image_width} > MAX_IMAGE_DIM) iw_m1 = IDW'(MAX_IMAGE_DIM - 1);
    else iw_m1 = IDW'(cfg.image_width - 13'd1);

    if (cfg.image_height == 13'd0) ih_m1 = '0;
    else if ({19'd0, cfg.image_height} > MAX_IMAGE_DIM) ih_m1 = IDW'(MAX_IMAGE_DIM - 1);
    else ih_m1 = IDW'(cfg.image_height - 13'd1);
  end

  always_comb begin
    cx  = start_image ? '0 : pixel_x;
    cy  = start_image ? '0 : pixel_y;
    cxt = start_image ? '0 : x_in_tile;
    cyt = start_image ? '0 : y_in_tile;
    ctc = start_image ? '0 : tile_column;
    ctb = start_image ? '0 : tile_band;

    x_end   = cxt >= fw_m1;
    y_end   = cyt >= fh_m1;
    row_end = cx >= iw_m1;
    img_end = row_end && (cy >= ih_m1);

    pix.alpha      = alpha;
    pix.col        = ctc;
    pix.band       = ctb;
    pix.start      = start_image;
    pix.y0         = (cyt == 8'd0);
    pix.tile_end   = x_end && y_end;
    pix.band_end   = row_end && y_end;
    pix.img_end    = img_end;
    pix.band_reset = row_end && (y_end || img_end);

    pixel_x_next     = cx + 12'd1;
    pixel_y_next     = cy;
    x_in_tile_next   = cxt + 8'd1;
    y_in_tile_next   = cyt;
    tile_column_next = ctc;
    tile_band_next   = ctb;
    if (img_end) begin
      pixel_x_next     = '0;
      pixel_y_next     = '0;
      x_in_tile_next   = '0;
      y_in_tile_next   = '0;
      tile_column_next = '0;
      tile_band_next   = '0;
    end else if (row_end) begin
      pixel_x_next     = '0;
      x_in_tile_next   = '0;
      tile_column_next = '0;
      pixel_y_next     = cy + 12'd1;
      if (y_end) begin
        y_in_tile_next = '0;
        if (ctb < CNT_SAT) tile_band_next = ctb + 7'd1;
      end else begin
        y_in_tile_next = cyt + 8'd1;
      end
    end else if (x_end) begin
      x_in_tile_next = '0;
      if (ctc < CNT_SAT) tile_column_next = ctc + 7'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_x     <= '0;
      pixel_y     <= '0;
      x_in_tile   <= '0;
      y_in_tile   <= '0;
      tile_column <= '0;
      tile_band   <= '0;
    end else if (accept) begin
      pixel_x     <= pixel_x_next;
      pixel_y     <= pixel_y_next;
      x_in_tile   <= x_in_tile_next;
      y_in_tile   <= y_in_tile_next;
      tile_column <= tile_column_next;
      tile_band   <= tile_band_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/tao_accum.sv
// Tile sum memory with read-modify-write, threshold test and band run logic.
// Depends on tao_pkg; takes pixel descriptors from tao_pos.
`default_nettype none

module tao_accum
  import tao_pkg::*;
#(
  parameter int MAX_COLUMNS = DEF_MAX_COLUMNS
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire cfg_t cfg,
  input  wire logic accept,
  input  wire pix_t pix_in,
  output logic      s1_valid,
  output logic      push,
  output result_t   res
);

  localparam int CW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;

  logic [SUM_W-1:0] mem [MAX_COLUMNS];

  pix_t             s1;
  logic [SUM_W-1:0] rdata, fwd_data, prev, sum;
  logic             fwd_sel;
  logic [SUM_W:0]   sum_wide;
  logic [CW-1:0]    rd_addr, wr_addr;
  logic             rd_in_range, wr_in_range, occ;

  logic [6:0] run_counter, run_counter_next, rc0, rc1;
  logic       run_open, run_open_next, ro0, ro1;
  logic       band_zero_reported, band_zero_reported_next, bzr0;

  assign rd_addr     = CW'(pix_in.col);
  assign wr_addr     = CW'(s1.col);
  assign rd_in_range = {25'd0, pix_in.col} < MAX_COLUMNS;
  assign wr_in_range = {25'd0, s1.col} < MAX_COLUMNS;

  always_comb begin
    prev     = fwd_sel ? fwd_data : rdata;
    sum_wide = {1'b0, prev} + {{(SUM_W-7){1'b0}}, s1.alpha};
    if (s1.y0) sum = {{(SUM_W-8){1'b0}}, s1.alpha};
    else if (sum_wide[SUM_W]) sum = SUM_MAX;
    else sum = sum_wide[SUM_W-1:0];
    occ = wr_in_range && (s1.col < cfg.column_count) && (sum >= cfg.alpha_threshold);

    rc0  = s1.start ? '0 : run_counter;
    ro0  = s1.start ? 1'b1 : run_open;
    bzr0 = s1.start ? 1'b0 : band_zero_reported;

    rc1 = rc0;
    ro1 = ro0;
    if (s1.tile_end) begin
      if (ro0 && occ) rc1 = rc0 + 7'd1;
      else ro1 = 1'b0;
    end

    push = 1'b0;
    band_zero_reported_next = bzr0;
    res.band_index      = s1.band[5:0];
    res.run_length      = rc1;
    res.effective_count = (rc1 != 7'd0) ? rc1 : cfg.column_count;
    res.last_band       = (cfg.row_count != 7'd0) && (s1.band == cfg.row_count - 7'd1);
    if (s1.band_end) begin
      push = s1_valid && (s1.band < cfg.row_count);
    end else if (s1.img_end && (s1.band == 7'd0) && !bzr0 && (cfg.row_count != 7'd0)) begin
      // image shorter than one tile: band 0 reported empty
      push = s1_valid;
      band_zero_reported_next = 1'b1;
      res.band_index      = '0;
      res.run_length      = '0;
      res.effective_count = cfg.column_count;
      res.last_band       = (cfg.row_count == 7'd1);
    end

    run_counter_next = rc1;
    run_open_next    = ro1;
    if (s1.band_reset) begin
      run_counter_next = '0;
      run_open_next    = 1'b1;
    end
    if (s1.img_end) band_zero_reported_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (s1_valid && wr_in_range) mem[wr_addr] <= sum;
    if (accept && rd_in_range) rdata <= mem[rd_addr];
    if (accept) begin
      s1       <= pix_in;
      fwd_data <= sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid           <= 1'b0;
      fwd_sel            <= 1'b0;
      run_counter        <= '0;
      run_open           <= 1'b1;
      band_zero_reported <= 1'b0;
    end else begin
      s1_valid <= accept;
      if (accept) fwd_sel <= s1_valid && wr_in_range && rd_in_range && (wr_addr == rd_addr);
      if (s1_valid) begin
        run_counter        <= run_counter_next;
        run_open           <= run_open_next;
        band_zero_reported <= band_zero_reported_next;
      end
    end
  end

  a_fwd_follows_write: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && fwd_sel) |-> $past(s1_valid) && ($past(wr_addr) == wr_addr))
    else $error("forwarded sum does not come from a write to the same entry");

  a_push_at_row_end: assert property (@(posedge clk) disable iff (rst)
    push |-> s1_valid && (s1.band_end || s1.img_end))
    else $error("result pushed away from a row end");

  a_run_reset: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1.band_reset) |=> (run_counter == 7'd0) && run_open)
    else $error("run state not cleared after band end");

endmodule

`default_nettype wire

// File: rtl/tao_outq.sv
// Three-word output queue that decouples the result stream from the pixel path.
// Depends on tao_pkg for the result word type.
`default_nettype none

module tao_outq
  import tao_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    push,
  input  wire result_t din,
  input  wire logic    out_ready,
  output logic         out_valid,
  output result_t      dout,
  output logic [1:0]   count
);

  result_t    ent0, ent1, ent2;
  result_t    ent0_next, ent1_next, ent2_next;
  logic       pop;
  logic [1:0] wr_slot;

  assign out_valid = (count != 2'd0);
  assign dout      = ent0;
  assign pop       = out_valid && out_ready;

  always_comb begin
    ent0_next = ent0;
    ent1_next = ent1;
    ent2_next = ent2;
    wr_slot   = count;
    if (pop) begin
      ent0_next = ent1;
      ent1_next = ent2;
      wr_slot   = count - 2'd1;
    end
    if (push) begin
      case (wr_slot)
        2'd0:    ent0_next = din;
        2'd1:    ent1_next = din;
        default: ent2_next = din;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    ent0 <= ent0_next;
    ent1 <= ent1_next;
    ent2 <= ent2_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !(count == 2'd3 && !pop))
    else $error("push into a full output queue");

  a_hold_when_stalled: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid && $stable(dout))
    else $error("head word changed while the receiver held off");

  a_empty_fill: assert property (@(posedge clk) disable iff (rst)
    !out_valid |=> (count <= 2'd1))
    else $error("empty queue took more than one word in a cycle");

endmodule

`default_nettype wire

// File: rtl/tile_alpha_occupancy_scan_unit.sv
// Tile alpha occupancy scan: one pixel per cycle, sustained; the input stalls only
// while the three-word result queue is backed up by the receiver, or in reset.
// Rate is set by the single accumulator read-modify-write per pixel, kept at
// one per cycle by forwarding the last written sum into the next read.
// A band result is pushed from the s1 register into the output queue, then m_axis.
// Reset (rst, synchronous): counters, run state and cfg registers to reset values;
// the tile sum memory is not cleared, so no clearing time after reset.
`default_nettype none

module tile_alpha_occupancy_scan_unit
  import tao_pkg::*;
#(
  parameter int MAX_COLUMNS   = DEF_MAX_COLUMNS,
  parameter int MAX_TILE_DIM  = DEF_MAX_TILE_DIM,
  parameter int MAX_IMAGE_DIM = DEF_MAX_IMAGE_DIM
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [23:0] cfg_data,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // alpha
  input  wire logic        s_axis_tuser,   // start_image
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,   // band_index, run_length, effective_count
  output logic             m_axis_tlast    // last_band
);

  cfg_t       cfg;
  pix_t       pix;
  result_t    res, qout;
  logic       accept, s1_valid, push;
  logic [1:0] q_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_width     <= RST_FRAME_WIDTH[8:0];
      cfg.frame_height    <= RST_FRAME_HEIGHT[8:0];
      cfg.image_width     <= RST_IMAGE_WIDTH[12:0];
      cfg.image_height    <= RST_IMAGE_HEIGHT[12:0];
      cfg.column_count    <= RST_COLUMN_COUNT[6:0];
      cfg.row_count       <= RST_ROW_COUNT[6:0];
      cfg.alpha_threshold <= RST_ALPHA_THRESH;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_FRAME_WIDTH:     cfg.frame_width     <= cfg_data[8:0];
        REG_FRAME_HEIGHT:    cfg.frame_height    <= cfg_data[8:0];
        REG_IMAGE_WIDTH:     cfg.image_width     <= cfg_data[12:0];
        REG_IMAGE_HEIGHT:    cfg.image_height    <= cfg_data[12:0];
        REG_COLUMN_COUNT:    cfg.column_count    <= cfg_data[6:0];
        REG_ROW_COUNT:       cfg.row_count       <= cfg_data[6:0];
        REG_ALPHA_THRESHOLD: cfg.alpha_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  // room for the word in flight plus a new one
  assign s_axis_tready = !rst && ((q_count <= 2'd1) || (q_count == 2'd2 && !s1_valid));
  assign accept        = s_axis_tvalid && s_axis_tready;

  tao_pos #(
    .MAX_TILE_DIM (MAX_TILE_DIM),
    .MAX_IMAGE_DIM(MAX_IMAGE_DIM)
  ) u_pos (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .accept     (accept),
    .alpha      (s_axis_tdata),
    .start_image(s_axis_tuser),
    .pix        (pix)
  );

  tao_accum #(
    .MAX_COLUMNS(MAX_COLUMNS)
  ) u_accum (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .accept  (accept),
    .pix_in  (pix),
    .s1_valid(s1_valid),
    .push    (push),
    .res     (res)
  );

  tao_outq u_outq (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .din      (res),
    .out_ready(m_axis_tready),
    .out_valid(m_axis_tvalid),
    .dout     (qout),
    .count    (q_count)
  );

  assign m_axis_tdata = {4'd0, qout.effective_count, qout.run_length, qout.band_index};
  assign m_axis_tlast = qout.last_band;

endmodule

`default_nettype wire
